// ----- src/b64t_pkg.sv -----
package b64t_pkg;

  localparam logic [7:0] CharDot  = 8'h2E;
  localparam logic [7:0] CharStar = 8'h2A;
  localparam logic [7:0] CharGt   = 8'h3E;
  localparam logic [7:0] CharDash = 8'h2D;
  localparam logic [7:0] CharUnd  = 8'h5F;
  localparam logic [5:0] SextetMask = 6'h3F;

  localparam int unsigned MaxChars = 4;

  typedef logic [MaxChars-1:0][7:0] char_arr_t;
  typedef logic [2:0] char_cnt_t;

  // one item's worth of characters handed to the output stage
  typedef struct packed {
    char_arr_t chars;
    char_cnt_t count;
    logic      last;
  } burst_t;

  function automatic logic [7:0] b64t_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v & SextetMask};
    if (w < 8'd26) begin
      c = w + 8'd65;
    end else if (w < 8'd52) begin
      c = w + 8'd71;
    end else if (w < 8'd62) begin
      c = w - 8'd4;
    end else if (w == 8'd62) begin
      c = CharDash;
    end else begin
      c = CharUnd;
    end
    return c;
  endfunction

  function automatic char_arr_t b64t_group(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2);
    logic [23:0] v;
    char_arr_t   r;
    v = {b0, b1, b2};
    r[0] = b64t_char(v[23:18]);
    r[1] = b64t_char(v[17:12]);
    r[2] = b64t_char(v[11:6]);
    r[3] = b64t_char(v[5:0]);
    return r;
  endfunction

endpackage

// ----- src/b64t_if.sv -----
interface b64t_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64t_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

// ----- src/b64t_encode.sv -----
module b64t_encode
  import b64t_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output burst_t     burst_o
);

  logic [1:0] mode_q;
  logic [7:0] p0_q, p0_d;
  logic [7:0] p1_q, p1_d;
  logic [1:0] pc_q, pc_d;
  logic       ge_q, ge_d;

  logic       split, filter, is_dot;
  logic [1:0] fcnt;
  logic [7:0] fp0, fp1;
  char_arr_t  tail;
  char_cnt_t  tcnt;
  char_arr_t  grp;

  assign split  = (mode_q != 2'd0);
  assign filter = mode_q[1];
  assign is_dot = split && (byte_i == CharDot);

  always_comb begin
    p0_d = p0_q;
    p1_d = p1_q;
    pc_d = pc_q;
    ge_d = ge_q;
    fcnt = 2'd0;
    fp0  = p0_q;
    fp1  = p1_q;
    if (is_dot) begin
      fcnt = pc_q;
      pc_d = 2'd0;
      ge_d = 1'b0;
    end else if (pc_q == 2'd2) begin
      pc_d = 2'd0;
      ge_d = 1'b1;
    end else begin
      if (pc_q == 2'd0) begin
        p0_d = byte_i;
        fp0  = byte_i;
      end else begin
        p1_d = byte_i;
      end
      fp1  = byte_i;
      pc_d = pc_q + 2'd1;
      if (last_i) begin
        fcnt = pc_q + 2'd1;
      end
    end
    if (last_i) begin
      pc_d = 2'd0;
      ge_d = 1'b0;
    end
  end

  // tail of a token: wildcard passthrough or two / three characters
  always_comb begin
    tail = '0;
    tcnt = '0;
    grp  = b64t_group(fp0, (fcnt == 2'd2) ? fp1 : 8'd0, 8'd0);
    if (fcnt != 2'd0) begin
      if (filter && fcnt == 2'd1 && !ge_q && (fp0 == CharStar || fp0 == CharGt)) begin
        tail[0] = fp0;
        tcnt    = 3'd1;
      end else begin
        tail = grp;
        tcnt = {1'b0, fcnt} + 3'd1;
      end
    end
  end

  always_comb begin
    burst_o.last = last_i;
    if (is_dot) begin
      burst_o.chars              = tail;
      burst_o.chars[tcnt[1:0]]   = CharDot;
      burst_o.count              = tcnt + 3'd1;
    end else if (pc_q == 2'd2) begin
      burst_o.chars = b64t_group(p0_q, p1_q, byte_i);
      burst_o.count = 3'd4;
    end else begin
      burst_o.chars = tail;
      burst_o.count = tcnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'd0;
      pc_q   <= 2'd0;
      ge_q   <= 1'b0;
      p0_q   <= 8'd0;
      p1_q   <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (take_i) begin
        pc_q <= pc_d;
        ge_q <= ge_d;
        p0_q <= p0_d;
        p1_q <= p1_d;
      end
    end
  end

endmodule

// ----- src/b64t_serial.sv -----
module b64t_serial
  import b64t_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  burst_t       burst_i,
  output logic         space_o,
  b64t_out_if.source   out_o
);

  char_arr_t  buf_q;
  char_cnt_t  rem_q;
  logic [1:0] idx_q;
  logic       last_q;
  logic       pop;

  assign out_o.valid    = (rem_q != 3'd0);
  assign out_o.out_char = buf_q[idx_q];
  assign out_o.out_last = last_q && (rem_q == 3'd1);
  assign pop            = out_o.valid && out_o.ready;
  // free once the final character of the held item leaves
  assign space_o        = (rem_q == 3'd0) || (pop && rem_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      rem_q <= burst_i.count;
      idx_q <= 2'd0;
    end else if (pop) begin
      rem_q <= rem_q - 3'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q  <= burst_i.chars;
      last_q <= burst_i.last;
    end
  end

endmodule

// ----- src/base64url_token_encoder_core.sv -----
// the first character of an item is offered in the cycle after the item is accepted
// throughput: one character per cycle while the output is ready; an item yielding n characters
// holds the output register until its last one leaves, the next item is taken in the cycle
// its last one leaves, and items yielding none are taken every cycle
// reset: mode returns to whole-value encoding, pending bytes and output register empty
module base64url_token_encoder_core
  import b64t_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  b64t_in_if.sink    in_i,
  b64t_out_if.source out_o
);

  burst_t burst;
  logic   space;
  logic   take;

  assign in_i.ready = space;
  assign take       = in_i.valid && space;

  b64t_encode u_encode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .byte_i      (in_i.in_byte),
    .last_i      (in_i.in_last),
    .burst_o     (burst)
  );

  b64t_serial u_serial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take),
    .burst_i (burst),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule
